// File: rtl/core/tgarle_pkg.sv
// ---------------------------------------------------------------------------
// tgarle_pkg
// Types and constants shared by the run-length TGA pixel decoder.
// ---------------------------------------------------------------------------
package tgarle_pkg;

    // Field widths
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned BPP_W    = 3;
    localparam int unsigned TOTAL_W  = 32;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned RES_W    = 5 * BYTE_W;   // red, green, blue, alpha, repeat
    localparam int unsigned CFG_IDX_W = 1;

    // Result queue depth: two slots for a double result, one for the head in flight
    localparam int unsigned QDEPTH   = 3;
    localparam int unsigned QCNT_W   = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BPP   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 1'b1;

    // Header byte fields
    localparam logic [BYTE_W-1:0] HDR_RUN_MASK   = 8'h80;
    localparam logic [BYTE_W-1:0] HDR_COUNT_MASK = 8'h7F;
    localparam logic [BYTE_W-1:0] ALPHA_OPAQUE   = 8'd255;

    localparam logic [BPP_W-1:0] BPP_RGB = 3'd3;
    localparam logic [BPP_W-1:0] BPP_RESET = 3'd4;
    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 32'd1;

    typedef enum logic [STATUS_W-1:0] {
        ST_PIXEL    = 3'd0,
        ST_EXACT    = 3'd1,
        ST_SHORT    = 3'd2,
        ST_TRUNC    = 3'd3,
        ST_OVERFLOW = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_PIXEL  = 2'd1,
        PH_ERROR  = 2'd2
    } phase_t;

    typedef struct packed {
        status_t             status;
        logic [BYTE_W-1:0]   red;
        logic [BYTE_W-1:0]   green;
        logic [BYTE_W-1:0]   blue;
        logic [BYTE_W-1:0]   alpha;
        logic [BYTE_W-1:0]   repeat_res;
        logic                final_result;
    } result_t;

    // Which of the two results of one byte are written to the queue
    typedef struct packed {
        logic first;
        logic second;
    } push_t;

endpackage

// File: rtl/core/tgarle_res_queue.sv
// ---------------------------------------------------------------------------
// tgarle_res_queue
// Three-entry shift queue for decoded results. Takes up to two results in
// one cycle and presents the oldest to the output channel.
// ---------------------------------------------------------------------------
module tgarle_res_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  tgarle_pkg::push_t   push,
    input  tgarle_pkg::result_t res_first,
    input  tgarle_pkg::result_t res_second,
    output logic                room_for_two,
    output logic                head_valid,
    input  logic                head_ready,
    output tgarle_pkg::result_t head
);
    import tgarle_pkg::*;

    result_t             ent_reg  [QDEPTH];
    result_t             ent_next [QDEPTH];
    logic [QCNT_W-1:0]   cnt_reg;
    logic [QCNT_W-1:0]   cnt_next;
    logic [QCNT_W-1:0]   base;
    logic                pop;

    assign pop          = head_valid && head_ready;
    assign head_valid   = (cnt_reg != '0);
    assign head         = ent_reg[0];
    assign room_for_two = (cnt_reg <= QCNT_W'(1));

    // Shift out the popped head, then write new results behind what remains
    always_comb begin
        base = cnt_reg - QCNT_W'(pop);
        for (int i = 0; i < QDEPTH; i++) begin
            if (pop && (i < QDEPTH - 1)) begin
                ent_next[i] = ent_reg[(i + 1) % QDEPTH];
            end else begin
                ent_next[i] = ent_reg[i];
            end
            if (push.first && (base == QCNT_W'(i))) begin
                ent_next[i] = res_first;
            end
            if (push.second && ((base + QCNT_W'(1)) == QCNT_W'(i))) begin
                ent_next[i] = res_second;
            end
        end
        cnt_next = base + QCNT_W'(push.first) + QCNT_W'(push.second);
    end

    // Hold the entries; payload needs no reset
    always_ff @(posedge aclk) begin
        for (int i = 0; i < QDEPTH; i++) begin
            ent_reg[i] <= ent_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

// File: rtl/core/tga_rle_pixel_decoder.sv
// ---------------------------------------------------------------------------
// tga_rle_pixel_decoder
// Run-length TGA pixel stream decoder: one compressed byte per transfer in,
// RGBA pixels with repeat counts and closing status words out.
// ---------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         tdata = data_byte, tlast = last_byte
//  m_axis    out        tdata = red..repeat_res, tuser = status, tlast = final_result
//  cfg       in         cfg_index 0 pixel size in bytes, 1 pixel_total
//
//  One byte is taken per cycle while the queue has room; its results are produced
//  in the same cycle into a three-entry result queue and leave one per cycle from
//  its head while m_axis_tready is high. A byte ending a packet on the last byte
//  yields two results; the input then stalls while the queue drains.
//  s_axis_tready depends only on queue occupancy (at most one entry held).
//  Reset (aresetn, synchronous) starts a new image and restores the
//  configuration to 4 bytes per pixel and a total of one pixel.
// ---------------------------------------------------------------------------
module tga_rle_pixel_decoder (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Compressed bytes
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [tgarle_pkg::BYTE_W-1:0]     s_axis_tdata,   // [7:0] data_byte
    input  logic                              s_axis_tlast,   // last_byte
    // Decoded results
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [39:32] repeat_res
    output logic [tgarle_pkg::RES_W-1:0]      m_axis_tdata,
    output logic [tgarle_pkg::STATUS_W-1:0]   m_axis_tuser,   // [2:0] status
    output logic                              m_axis_tlast,   // final_result
    // Configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tgarle_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tgarle_pkg::TOTAL_W-1:0]    cfg_data
);
    import tgarle_pkg::*;

    // Configuration
    logic [BPP_W-1:0]     bpp_reg;
    logic [TOTAL_W-1:0]   total_reg;

    // Decoder state
    phase_t               phase_reg,    phase_next;
    logic                 run_mode_reg, run_mode_next;
    logic [BYTE_W-1:0]    left_reg,     left_next;
    logic [1:0]           bpos_reg,     bpos_next;
    logic [23:0]          partial_reg,  partial_next;
    logic [TOTAL_W-1:0]   produced_reg, produced_next;

    logic                 accept;
    logic                 last;
    logic [BYTE_W-1:0]    din;
    logic                 rgb_only;
    logic [1:0]           last_pos;
    logic [BYTE_W-1:0]    count;
    logic [TOTAL_W:0]     claim_sum;
    status_t              closing;
    logic                 restart;
    logic                 done;
    push_t                push;
    result_t              res_first;
    result_t              res_second;
    result_t              pix;
    result_t              head;
    logic                 room_for_two;

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign last      = s_axis_tlast;
    assign din       = s_axis_tdata;
    assign rgb_only  = (bpp_reg == BPP_RGB);
    assign last_pos  = rgb_only ? 2'd2 : 2'd3;
    assign count     = (din & HDR_COUNT_MASK) + BYTE_W'(1);
    assign claim_sum = {1'b0, produced_reg} + (TOTAL_W+1)'(count);
    assign cfg_ready = 1'b1;

    // Closing status from the pixels claimed so far
    always_comb begin
        priority if (produced_reg == total_reg) begin
            closing = ST_EXACT;
        end else if (produced_reg < total_reg) begin
            closing = ST_SHORT;
        end else begin
            closing = ST_OVERFLOW;
        end
    end

    // Assemble the completed pixel from the stored bytes and this byte
    always_comb begin
        pix              = '0;
        pix.status       = ST_PIXEL;
        pix.blue         = partial_reg[7:0];
        pix.green        = partial_reg[15:8];
        pix.red          = rgb_only ? din : partial_reg[23:16];
        pix.alpha        = rgb_only ? ALPHA_OPAQUE : din;
        pix.repeat_res   = run_mode_reg ? left_reg : BYTE_W'(1);
        pix.final_result = 1'b0;
    end

    // Decode one byte: next state and the results it causes
    always_comb begin
        phase_next    = phase_reg;
        run_mode_next = run_mode_reg;
        left_next     = left_reg;
        bpos_next     = bpos_reg;
        partial_next  = partial_reg;
        produced_next = produced_reg;
        restart       = 1'b0;
        done          = 1'b0;
        push          = '0;
        res_first     = '0;
        res_second    = '0;
        res_first.final_result  = 1'b1;
        res_second.final_result = 1'b1;
        res_second.status       = closing;

        if (accept) begin
            unique case (phase_reg)
                PH_ERROR: begin
                    // Swallow until the end of the image
                    restart = last;
                end
                PH_HEADER: begin
                    if (produced_reg >= total_reg) begin
                        // Output full: ignore bytes, report at the end
                        if (last) begin
                            push.first       = 1'b1;
                            res_first.status = closing;
                            restart          = 1'b1;
                        end
                    end else if (last) begin
                        push.first       = 1'b1;
                        res_first.status = ST_TRUNC;
                        restart          = 1'b1;
                    end else if (claim_sum > {1'b0, total_reg}) begin
                        push.first       = 1'b1;
                        res_first.status = ST_OVERFLOW;
                        phase_next       = PH_ERROR;
                    end else begin
                        run_mode_next = ((din & HDR_RUN_MASK) != '0);
                        left_next     = count;
                        bpos_next     = 2'd0;
                        partial_next  = '0;
                        produced_next = claim_sum[TOTAL_W-1:0];
                        phase_next    = PH_PIXEL;
                    end
                end
                PH_PIXEL: begin
                    if (bpos_reg < last_pos) begin
                        // Store this byte of the pixel
                        unique case (bpos_reg)
                            2'd0:    partial_next[7:0]   = din;
                            2'd1:    partial_next[15:8]  = din;
                            2'd2:    partial_next[23:16] = din;
                            default: partial_next        = partial_reg;
                        endcase
                        bpos_next = bpos_reg + 2'd1;
                        if (last) begin
                            push.first       = 1'b1;
                            res_first.status = ST_TRUNC;
                            restart          = 1'b1;
                        end
                    end else begin
                        // Pixel complete
                        done         = run_mode_reg || (left_reg <= BYTE_W'(1));
                        bpos_next    = 2'd0;
                        partial_next = '0;
                        if (!run_mode_reg && (left_reg != '0)) begin
                            left_next = left_reg - BYTE_W'(1);
                        end
                        push.first = 1'b1;
                        if (!done) begin
                            if (last) begin
                                res_first.status = ST_TRUNC;
                                restart          = 1'b1;
                            end else begin
                                res_first = pix;
                            end
                        end else begin
                            res_first  = pix;
                            phase_next = PH_HEADER;
                            left_next  = '0;
                            if (last) begin
                                push.second = 1'b1;
                                restart     = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    phase_next = PH_HEADER;
                end
            endcase
        end

        // Start a new image
        if (restart) begin
            phase_next    = PH_HEADER;
            run_mode_next = 1'b0;
            left_next     = '0;
            bpos_next     = 2'd0;
            partial_next  = '0;
            produced_next = '0;
        end
    end

    // Advance decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HEADER;
            run_mode_reg <= 1'b0;
            left_reg     <= '0;
            bpos_reg     <= 2'd0;
            partial_reg  <= '0;
            produced_reg <= '0;
        end else begin
            phase_reg    <= phase_next;
            run_mode_reg <= run_mode_next;
            left_reg     <= left_next;
            bpos_reg     <= bpos_next;
            partial_reg  <= partial_next;
            produced_reg <= produced_next;
        end
    end

    // Take configuration transfers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg   <= BPP_RESET;
            total_reg <= TOTAL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_BPP:   bpp_reg   <= cfg_data[BPP_W-1:0];
                CFG_TOTAL: total_reg <= cfg_data;
                default:   total_reg <= total_reg;
            endcase
        end
    end

    tgarle_res_queue u_queue (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push         (push),
        .res_first    (res_first),
        .res_second   (res_second),
        .room_for_two (room_for_two),
        .head_valid   (m_axis_tvalid),
        .head_ready   (m_axis_tready),
        .head         (head)
    );

    assign s_axis_tready = room_for_two;
    assign m_axis_tdata  = {head.repeat_res, head.alpha, head.blue, head.green, head.red};
    assign m_axis_tuser  = head.status;
    assign m_axis_tlast  = head.final_result;

endmodule

// File: tb/sv/tga_rle_pixel_decoder_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tga_rle_pixel_decoder_tb
// Self-checking bench for the run-length TGA pixel decoder. Compressed bytes
// go in on the byte stream, and a cycle-free model of the decoder predicts
// the pixel and status words for each accepted transfer. Directed packets
// come first, then configuration changes inside an image and a long
// back-pressure stretch. Random images follow: mostly well-formed, some
// short, truncated, overflowing or pure noise. Both sides idle at random,
// except in the closing stretch and, on the byte side, the back-pressure test.
// ---------------------------------------------------------------------------
module tga_rle_pixel_decoder_tb;
    import tgarle_pkg::*;

    localparam int unsigned SETTLE_CYCLES    = 4;
    localparam int unsigned LONG_HOLD_CYCLES = 80;
    localparam int unsigned DRAIN_LIMIT      = 5000;
    localparam int unsigned RANDOM_ITEMS     = 600;
    localparam int unsigned STEADY_ITEMS     = 150;

    typedef enum int unsigned {
        IMG_FULL,
        IMG_SHORT,
        IMG_TRAILING,
        IMG_TRUNCATED,
        IMG_OVERFLOW,
        IMG_NOISE
    } image_kind_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [BYTE_W-1:0]    s_axis_tdata  = '0;     // [7:0] data_byte
    logic                 s_axis_tlast  = 1'b0;   // last_byte
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b1;
    // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [39:32] repeat_res
    logic [RES_W-1:0]     m_axis_tdata;
    logic [STATUS_W-1:0]  m_axis_tuser;           // [2:0] status
    logic                 m_axis_tlast;           // final_result
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [TOTAL_W-1:0]   cfg_data      = '0;

    // Decoder state as the bench tracks it
    logic [BPP_W-1:0]     pred_bpp      = BPP_RESET;
    logic [TOTAL_W-1:0]   pred_total    = TOTAL_RESET;
    phase_t               pred_phase    = PH_HEADER;
    logic                 pred_run      = 1'b0;
    logic [7:0]           pred_left     = '0;
    logic [1:0]           pred_pos      = '0;
    logic [23:0]          pred_partial  = '0;
    logic [TOTAL_W-1:0]   pred_produced = '0;

    result_t              results_due[$];
    int unsigned          failures      = 0;
    int unsigned          bytes_sent    = 0;
    bit                   tx_idle_en    = 1'b1;
    bit                   rx_idle_en    = 1'b1;
    bit                   hold_request  = 1'b0;
    int unsigned          hold_left     = 0;
    int unsigned          rx_gap_left   = 0;

    tga_rle_pixel_decoder i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Decoder model
    // -----------------------------------------------------------------------
    task automatic start_image();
        pred_phase    = PH_HEADER;
        pred_run      = 1'b0;
        pred_left     = '0;
        pred_pos      = '0;
        pred_partial  = '0;
        pred_produced = '0;
    endtask

    task automatic add_result(input status_t st, input logic [7:0] red, green, blue, alpha,
                              rep, input logic fin);
        result_t r;
        r.status       = st;
        r.red          = red;
        r.green        = green;
        r.blue         = blue;
        r.alpha        = alpha;
        r.repeat_res   = rep;
        r.final_result = fin;
        results_due.push_back(r);
    endtask

    task automatic add_status(input status_t st);
        add_result(st, '0, '0, '0, '0, '0, 1'b1);
    endtask

    function automatic status_t closing_status();
        if (pred_produced == pred_total)
            return ST_EXACT;
        else if (pred_produced < pred_total)
            return ST_SHORT;
        else
            return ST_OVERFLOW;
    endfunction

    task automatic decode_byte(input logic [7:0] data, input logic last);
        int unsigned px_bytes;
        logic [7:0]  count;
        logic [32:0] claimed;
        logic [31:0] shifted;
        logic [7:0]  red, green, blue, alpha, rep;
        logic        done;
        px_bytes = (pred_bpp == BPP_RGB) ? 3 : 4;
        case (pred_phase)
            PH_ERROR: begin
                // swallow everything up to the end of the image
                if (last)
                    start_image();
            end
            PH_HEADER: begin
                count   = (data & HDR_COUNT_MASK) + 8'd1;
                claimed = {1'b0, pred_produced} + 33'(count);
                if (pred_produced >= pred_total) begin
                    // output already full: ignore until the image ends
                    if (last) begin
                        add_status(closing_status());
                        start_image();
                    end
                end else if (last) begin
                    add_status(ST_TRUNC);
                    start_image();
                end else if (claimed > {1'b0, pred_total}) begin
                    add_status(ST_OVERFLOW);
                    pred_phase = PH_ERROR;
                end else begin
                    pred_run      = (data & HDR_RUN_MASK) != 0;
                    pred_left     = count;
                    pred_pos      = '0;
                    pred_partial  = '0;
                    pred_produced = claimed[31:0];
                    pred_phase    = PH_PIXEL;
                end
            end
            default: begin
                if (32'(pred_pos) < px_bytes - 1) begin
                    // collect another stored byte of the pixel
                    shifted      = {24'd0, data} << {pred_pos, 3'b000};
                    pred_partial = pred_partial | shifted[23:0];
                    pred_pos     = pred_pos + 2'd1;
                    if (last) begin
                        add_status(ST_TRUNC);
                        start_image();
                    end
                end else begin
                    blue  = pred_partial[7:0];
                    green = pred_partial[15:8];
                    if (px_bytes == 3) begin
                        red   = data;
                        alpha = ALPHA_OPAQUE;
                    end else begin
                        red   = pred_partial[23:16];
                        alpha = data;
                    end
                    if (pred_run) begin
                        rep  = pred_left;
                        done = 1'b1;
                    end else begin
                        rep  = 8'd1;
                        done = pred_left <= 8'd1;
                        if (pred_left > 0)
                            pred_left--;
                    end
                    pred_pos     = '0;
                    pred_partial = '0;
                    if (!done && last) begin
                        // packet cut short: the completed pixel is dropped
                        add_status(ST_TRUNC);
                        start_image();
                    end else begin
                        add_result(ST_PIXEL, red, green, blue, alpha, rep, 1'b0);
                        if (done) begin
                            pred_phase = PH_HEADER;
                            pred_left  = '0;
                            if (last) begin
                                add_status(closing_status());
                                start_image();
                            end
                        end
                    end
                end
            end
        endcase
    endtask

    // -----------------------------------------------------------------------
    // Result side: random stalls, long hold on request, checking
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin : drive_result_ready
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (rx_gap_left > 0) begin
            rx_gap_left--;
            m_axis_tready <= 1'b0;
        end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
            rx_gap_left = $urandom_range(0, 6);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic check_field(input string field, input logic [7:0] want, got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            failures++;
        end
    endtask

    always @(posedge aclk) begin : check_results
        result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (results_due.size() == 0) begin
                $error("result with nothing outstanding: status %0d", m_axis_tuser);
                failures++;
            end else begin
                want = results_due.pop_front();
                check_field("status", 8'(want.status), 8'(m_axis_tuser));
                check_field("red", want.red, m_axis_tdata[7:0]);
                check_field("green", want.green, m_axis_tdata[15:8]);
                check_field("blue", want.blue, m_axis_tdata[23:16]);
                check_field("alpha", want.alpha, m_axis_tdata[31:24]);
                check_field("repeat_res", want.repeat_res, m_axis_tdata[39:32]);
                check_field("final_result", 8'(want.final_result), 8'(m_axis_tlast));
            end
        end
    end

    // -----------------------------------------------------------------------
    // Byte side and configuration
    // -----------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] data, input logic last);
        if (tx_idle_en && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= last;
        do @(posedge aclk); while (!s_axis_tready);
        decode_byte(data, last);
        bytes_sent++;
    endtask

    // Hold the byte stream until every outstanding result has left
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_config(input logic [BPP_W-1:0] bpp, input logic [TOTAL_W-1:0] total);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_BPP;
        cfg_data  <= TOTAL_W'(bpp);
        do @(posedge aclk); while (!cfg_ready);
        pred_bpp  = bpp;
        cfg_index <= CFG_TOTAL;
        cfg_data  <= total;
        do @(posedge aclk); while (!cfg_ready);
        pred_total = total;
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_image();
        logic [7:0]  img[$];
        image_kind_t kind;
        int unsigned px_bytes, goal, left, cnt, cut;
        logic        run;
        px_bytes = (pred_bpp == BPP_RGB) ? 3 : 4;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: kind = IMG_FULL;
            4:          kind = IMG_SHORT;
            5:          kind = IMG_TRAILING;
            6, 7:       kind = IMG_TRUNCATED;
            8:          kind = IMG_OVERFLOW;
            default:    kind = IMG_NOISE;
        endcase
        // large totals cannot be filled here, so those images end short
        if (pred_total > 40) begin
            goal = $urandom_range(1, 24);
            if (kind == IMG_OVERFLOW || kind == IMG_TRAILING)
                kind = IMG_FULL;
        end else if (kind == IMG_SHORT && pred_total > 1) begin
            goal = $urandom_range(1, pred_total - 1);
        end else if (kind == IMG_OVERFLOW) begin
            goal = $urandom_range(0, pred_total - 1);
        end else begin
            goal = pred_total;
        end

        // well-formed packets covering the pixel goal
        left = goal;
        while (left > 0) begin
            run = $urandom_range(0, 1);
            if (run && $urandom_range(0, 3) == 0)
                cnt = $urandom_range(1, (left < 128) ? left : 128);
            else
                cnt = $urandom_range(1, (left < 5) ? left : 5);
            img.push_back({run, 7'(cnt - 1)});
            repeat ((run ? 1 : cnt) * px_bytes) img.push_back(8'($urandom));
            left -= cnt;
        end

        case (kind)
            IMG_TRAILING: begin
                repeat ($urandom_range(1, 3)) img.push_back(8'($urandom));
            end
            IMG_OVERFLOW: begin
                cnt = $urandom_range(pred_total - goal + 1, 128);
                img.push_back({1'($urandom_range(0, 1)), 7'(cnt - 1)});
                repeat ($urandom_range(0, 4)) img.push_back(8'($urandom));
            end
            IMG_TRUNCATED: begin
                if (img.size() > 1) begin
                    cut = $urandom_range(1, img.size() - 1);
                    while (img.size() > cut)
                        void'(img.pop_back());
                end
            end
            IMG_NOISE: begin
                img.delete();
                repeat ($urandom_range(1, 12)) img.push_back(8'($urandom));
            end
            default: ;
        endcase

        foreach (img[i])
            send_byte(img[i], i == img.size() - 1);
    endtask

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------
    task automatic test_directed_packets();
        // BGR, three pixels: literal of one, then a run of two fills the image
        write_config(BPP_RGB, 32'd3);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h81, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        // output full: bytes ignored, last one closes exact
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b1);
        wait_drained();

        // BGRA, longest run ending on the last byte closes short
        write_config(BPP_RESET, 32'd200);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'h44, 1'b1);
        // last byte on a header
        send_byte(8'h7F, 1'b1);
        // literal of two, cut inside the second pixel
        send_byte(8'h01, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b0);
        send_byte(8'h78, 1'b0);
        send_byte(8'h9A, 1'b0);
        send_byte(8'hBC, 1'b1);
        wait_drained();

        // header asks for more than the total; the rest is swallowed silently
        write_config(BPP_RESET, 32'd1);
        send_byte(8'h01, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h00, 1'b1);
        wait_drained();
    endtask

    task automatic test_config_mid_image();
        write_config(BPP_RESET, 32'd6);
        // literal of two, first pixel begun as BGRA
        send_byte(8'h01, 1'b0);
        send_byte(8'hA1, 1'b0);
        send_byte(8'hB2, 1'b0);
        wait_drained();
        // switch to BGR: the third byte now completes the pixel
        write_config(BPP_RGB, 32'd6);
        send_byte(8'hC3, 1'b0);
        wait_drained();
        // drop the total below the claimed count; an unlisted size acts as BGRA
        write_config(3'd7, 32'd1);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b1);
        wait_drained();
    endtask

    task automatic test_back_pressure();
        int unsigned i;
        write_config(BPP_RGB, 32'd20);
        tx_idle_en   = 1'b0;
        hold_request = 1'b1;
        // literal of twenty pixels offered back to back against a stalled sink
        send_byte(8'h13, 1'b0);
        for (i = 0; i < 60; i++)
            send_byte(8'($urandom), i == 59);
        wait_drained();
        tx_idle_en = 1'b1;
    endtask

    task automatic test_random_images(input int unsigned budget);
        int unsigned        stop_at;
        logic [BPP_W-1:0]   bpp;
        logic [TOTAL_W-1:0] total;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at) begin
            // reconfigure between images now and then, once the sink is empty
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 9))
                    0:          bpp = 3'($urandom);
                    1, 2, 3, 4: bpp = BPP_RGB;
                    default:    bpp = BPP_RESET;
                endcase
                case ($urandom_range(0, 9))
                    0:       total = TOTAL_RESET;
                    1:       total = '1;
                    2:       total = $urandom;
                    3:       total = $urandom_range(13, 40);
                    default: total = $urandom_range(2, 12);
                endcase
                wait_drained();
                write_config(bpp, total);
            end
            send_random_image();
        end
    endtask

    initial begin : run_tests
        int unsigned waited;
        waited = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_packets();
        test_config_mid_image();
        test_back_pressure();
        test_random_images(RANDOM_ITEMS);

        // closing stretch without idling on either side
        wait_drained();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        test_random_images(STEADY_ITEMS);

        s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (results_due.size() != 0) begin
            $error("%0d results never arrived", results_due.size());
            failures++;
        end
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $error("run did not complete in time");
        $display("TEST FAILED");
        $finish;
    end

endmodule
